/* rtl/kts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, codes and helpers for the keyword token scanner.
// ----------------------------------------------------------------------------
package kts_pkg;

   localparam int MAX_TOKEN_LEN = 8;
   localparam int LEX_BYTES     = 8;
   localparam int LEX_W         = 8 * LEX_BYTES;
   localparam int LEN_W         = 4;
   localparam int KIND_W        = 5;
   localparam int MODE_W        = 3;
   localparam int NUM_KEYWORDS  = 8;

   // scanner modes
   localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NUM     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ID      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ASSIGN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd4;

   // token kinds
   localparam logic [KIND_W-1:0] K_ID     = 5'd8;
   localparam logic [KIND_W-1:0] K_NUM    = 5'd9;
   localparam logic [KIND_W-1:0] K_ASSIGN = 5'd10;
   localparam logic [KIND_W-1:0] K_EQ     = 5'd11;
   localparam logic [KIND_W-1:0] K_LT     = 5'd12;
   localparam logic [KIND_W-1:0] K_PLUS   = 5'd13;
   localparam logic [KIND_W-1:0] K_MINUS  = 5'd14;
   localparam logic [KIND_W-1:0] K_TIMES  = 5'd15;
   localparam logic [KIND_W-1:0] K_OVER   = 5'd16;
   localparam logic [KIND_W-1:0] K_LPAREN = 5'd17;
   localparam logic [KIND_W-1:0] K_RPAREN = 5'd18;
   localparam logic [KIND_W-1:0] K_SEMI   = 5'd19;
   localparam logic [KIND_W-1:0] K_ERROR  = 5'd20;
   localparam logic [KIND_W-1:0] K_EOF    = 5'd21;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_TIMES  = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // keywords packed first character in low byte, in kind order
   localparam logic [LEX_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6E65_6874,   // then
      64'h0000_0000_6573_6C65,   // else
      64'h0000_0000_0064_6E65,   // end
      64'h0000_7461_6570_6572,   // repeat
      64'h0000_006C_6974_6E75,   // until
      64'h0000_0000_6461_6572,   // read
      64'h0000_0065_7469_7277    // write
   };
   localparam logic [LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5
   };

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LEX_W-1:0]  lexeme;
      logic [LEN_W-1:0]  length;
      logic              overflow;
   } scan_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEX_W-1:0]  lexeme;
      logic [LEN_W-1:0]  length;
      logic              truncated;
      logic              last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_0:CH_9]};
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_LF, CH_NUL};
   endfunction

   function automatic scan_state_type add_char(input scan_state_type s,
                                               input logic [7:0] c);
      scan_state_type r;
      r = s;
      if (s.length < LEN_W'(MAX_TOKEN_LEN)) begin
         for (int i = 0; i < LEX_BYTES; i++) begin
            if (s.length == LEN_W'(i))
               r.lexeme[8*i +: 8] = c;
         end
         r.length = s.length + 1'b1;
      end else begin
         r.overflow = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [KIND_W-1:0] classify_word(input scan_state_type s);
      logic [KIND_W-1:0] k;
      k = K_ID;
      if (!s.overflow) begin
         for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
            if (s.length == KW_LEN[i] && s.lexeme == KW_TEXT[i])
               k = KIND_W'(i);
         end
      end
      return k;
   endfunction

   function automatic token_type make_token(input logic [KIND_W-1:0] kind,
                                            input scan_state_type s);
      token_type t;
      t.kind      = kind;
      t.lexeme    = s.lexeme;
      t.length    = s.length;
      t.truncated = s.overflow;
      t.last      = 1'b0;
      return t;
   endfunction

endpackage

/* rtl/kts_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_step
// One scanner step: from the current state and one request, the next state
// and up to two tokens; where there are two, the first closes a pending lexeme.
// ----------------------------------------------------------------------------
module kts_step (
   input  kts_pkg::scan_state_type state,
   input  logic [7:0]              char_code,
   input  logic                    end_of_input,
   output kts_pkg::scan_state_type next_state,
   output logic [1:0]              tok_count,
   output kts_pkg::token_type      tok0,
   output kts_pkg::token_type      tok1
);
   import kts_pkg::*;

   scan_state_type   clear_st;
   scan_state_type   start_st;
   scan_state_type   one_st;
   token_type        tok_a;
   token_type        tok_b;
   logic             a_vld;
   logic             b_vld;
   logic             rescan;
   logic [KIND_W-1:0] op_kind;

   always_comb begin
      clear_st = '0;
      one_st   = add_char(clear_st, char_code);

      case (char_code)
         CH_EQ:     op_kind = K_EQ;
         CH_LT:     op_kind = K_LT;
         CH_PLUS:   op_kind = K_PLUS;
         CH_MINUS:  op_kind = K_MINUS;
         CH_TIMES:  op_kind = K_TIMES;
         CH_SLASH:  op_kind = K_OVER;
         CH_LPAREN: op_kind = K_LPAREN;
         CH_RPAREN: op_kind = K_RPAREN;
         CH_SEMI:   op_kind = K_SEMI;
         default:   op_kind = K_ERROR;
      endcase
   end

   // first pass: the pending mode
   always_comb begin
      next_state = state;
      tok_a      = '0;
      a_vld      = 1'b0;
      rescan     = 1'b1;
      case (state.mode)
         MODE_NUM: begin
            if (!end_of_input && is_digit(char_code)) begin
               next_state = add_char(state, char_code);
               rescan     = 1'b0;
            end else begin
               tok_a = make_token(K_NUM, state);
               a_vld = 1'b1;
            end
         end
         MODE_ID: begin
            if (!end_of_input && is_letter(char_code)) begin
               next_state = add_char(state, char_code);
               rescan     = 1'b0;
            end else begin
               tok_a = make_token(classify_word(state), state);
               a_vld = 1'b1;
            end
         end
         MODE_ASSIGN: begin
            a_vld = 1'b1;
            if (!end_of_input && char_code == CH_EQ) begin
               tok_a      = make_token(K_ASSIGN, add_char(state, char_code));
               next_state = clear_st;
               rescan     = 1'b0;
            end else begin
               tok_a = make_token(K_ERROR, state);
            end
         end
         MODE_COMMENT: begin
            rescan = 1'b0;
            if (end_of_input) begin
               tok_a      = make_token(K_EOF, clear_st);
               a_vld      = 1'b1;
               next_state = clear_st;
            end else if (char_code == CH_RBRACE) begin
               next_state = clear_st;
            end
         end
         default: ;
      endcase

      // start state, also the rescan of a byte that closed a token
      start_st = clear_st;
      tok_b    = '0;
      b_vld    = 1'b0;
      if (end_of_input) begin
         tok_b = make_token(K_EOF, clear_st);
         b_vld = 1'b1;
      end else if (is_digit(char_code)) begin
         start_st      = one_st;
         start_st.mode = MODE_NUM;
      end else if (is_letter(char_code)) begin
         start_st      = one_st;
         start_st.mode = MODE_ID;
      end else if (char_code == CH_COLON) begin
         start_st      = one_st;
         start_st.mode = MODE_ASSIGN;
      end else if (is_space(char_code)) begin
         start_st = clear_st;
      end else if (char_code == CH_LBRACE) begin
         start_st.mode = MODE_COMMENT;
      end else begin
         tok_b = make_token(op_kind, one_st);
         b_vld = 1'b1;
      end

      if (rescan)
         next_state = start_st;
      else
         b_vld = 1'b0;
   end

   always_comb begin
      tok0      = a_vld ? tok_a : tok_b;
      tok1      = tok_b;
      tok_count = {1'b0, a_vld} + {1'b0, b_vld};
      tok0.last = (tok_count == 2'd1);
      tok1.last = 1'b1;
   end

endmodule

/* rtl/kts_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_outq
// Two-entry result queue. Takes zero, one or two tokens per cycle and
// presents the oldest one on its head.
// ----------------------------------------------------------------------------
module kts_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  kts_pkg::token_type push0,
   input  kts_pkg::token_type push1,
   input  logic               pop,
   output logic [1:0]         count_after_pop,
   output logic               head_valid,
   output kts_pkg::token_type head
);
   import kts_pkg::*;

   token_type  q_ff [2];
   token_type  q_in [2];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   always_comb begin
      count_after_pop = cnt_ff - {1'b0, pop};
      cnt_in          = count_after_pop + push_count;
      q_in[0]         = pop ? q_ff[1] : q_ff[0];
      q_in[1]         = q_ff[1];
      if (push_count == 2'd2) begin
         q_in[0] = push0;
         q_in[1] = push1;
      end else if (push_count == 2'd1) begin
         if (count_after_pop == 2'd0)
            q_in[0] = push0;
         else
            q_in[1] = push0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= '0;
      else
         cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[0];

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> (count_after_pop + push_count) <= 2'd2)
      else $error("result queue overfilled");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |=> cnt_ff == 2'd2 && !q_ff[0].last && q_ff[1].last)
      else $error("token pair stored out of order");
`endif

endmodule

/* rtl/keyword_token_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_token_scanner_top
// Lexical scanner: one source byte per request in, tokens out.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low. A request waits in
// the input register, where the scanner step runs and its tokens go into a
// two-entry result queue; the first token shows on rsp_ from the queue
// register. Most bytes make zero or one token and sustain one request per
// cycle while rsp_stall is low. A byte that closes a pending number,
// identifier or ':' and is itself a token (or end of input) makes two
// tokens; the two-entry queue must then be empty, so such a request can
// wait in the input register until it is. Output is one token per cycle
// while rsp_stall is low; rsp_last_of_run marks the final token of a
// request. Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module keyword_token_scanner_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_char_code,
   input  logic                        req_end_of_input,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kts_pkg::KIND_W-1:0]  rsp_token_kind,
   output logic [kts_pkg::LEX_W-1:0]   rsp_lexeme_bytes,
   output logic [kts_pkg::LEN_W-1:0]   rsp_lexeme_length,
   output logic                        rsp_truncated,
   output logic                        rsp_last_of_run
);
   import kts_pkg::*;

   logic           in_vld_ff;
   logic           in_vld_in;
   logic [7:0]     in_char_ff;
   logic           in_eoi_ff;
   scan_state_type st_ff;
   scan_state_type st_in;
   scan_state_type step_state;
   logic [1:0]     tok_count;
   token_type      tok0;
   token_type      tok1;
   token_type      head;
   logic [1:0]     cnt_after_pop;
   logic           pop;
   logic           process;
   logic           req_take;

   kts_step u_step (
      .state        (st_ff),
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .next_state   (step_state),
      .tok_count    (tok_count),
      .tok0         (tok0),
      .tok1         (tok1)
   );

   assign pop     = rsp_valid && !rsp_stall;
   assign process = in_vld_ff && ({1'b0, cnt_after_pop} + {1'b0, tok_count} <= 3'd2);

   kts_outq u_outq (
      .clock           (clock),
      .reset           (reset),
      .push_count      (process ? tok_count : 2'd0),
      .push0           (tok0),
      .push1           (tok1),
      .pop             (pop),
      .count_after_pop (cnt_after_pop),
      .head_valid      (rsp_valid),
      .head            (head)
   );

   assign req_stall = in_vld_ff && !process;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take)
         in_vld_in = 1'b1;
      else if (process)
         in_vld_in = 1'b0;
      st_in = process ? step_state : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         st_ff     <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         st_ff     <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   assign rsp_token_kind    = head.kind;
   assign rsp_lexeme_bytes  = head.lexeme;
   assign rsp_lexeme_length = head.length;
   assign rsp_truncated     = head.truncated;
   assign rsp_last_of_run   = head.last;

`ifndef ASSERT_OFF
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !process |=> in_vld_ff && $stable(in_char_ff) && $stable(in_eoi_ff))
      else $error("held request lost or changed");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(st_ff))
      else $error("scanner state moved without a request");

   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      process && in_eoi_ff |=> st_ff.mode == MODE_START && st_ff.length == '0)
      else $error("scanner not back in start after end of input");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff.length <= LEN_W'(MAX_TOKEN_LEN))
      else $error("pending lexeme length beyond limit");
`endif

endmodule
